>>> hw/rtl/distinct_prime_factor_counter_defines.svh
// Assertion macros shared by the block's modules.
`ifndef DISTINCT_PRIME_FACTOR_COUNTER_DEFINES_SVH
`define DISTINCT_PRIME_FACTOR_COUNTER_DEFINES_SVH

`ifndef SYNTH
`define DPFC_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("dpfc: assertion failed");
`define DPFC_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) (prop)) \
        else $error("dpfc: assertion failed");
`else
`define DPFC_ASSERT(label, prop)
`define DPFC_ASSERT_ALWAYS(label, prop)
`endif

`endif

>>> hw/rtl/dpfc_pkg.sv
package dpfc_pkg;

    localparam int unsigned VALUE_W   = 16;
    localparam int unsigned COUNT_W   = 3;
    localparam int unsigned S_TDATA_W = 16;
    localparam int unsigned M_TDATA_W = 24;

    typedef enum logic [2:0] {
        SV_INIT,
        SV_PRIME_RD,
        SV_PRIME_CHK,
        SV_MARK,
        SV_DONE
    } t_sieve_state;

    typedef enum logic [1:0] {
        Q_IDLE,
        Q_LOOK,
        Q_DONE
    } t_query_state;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage

>>> hw/rtl/distinct_prime_factor_counter.sv
// Distinct prime factor counter.
// After reset the block fills a table with the smallest prime factor and the
// matching cofactor of every index below 2^TABLE_BITS. It first writes every
// entry and then runs the marking pass of the sieve; s_axis_tready stays low
// until it is complete.
// Input transactions carry the value to factor in s_axis_tdata. Output
// transactions carry the count of distinct prime divisors and the smallest
// prime factor; values below two or beyond the table give zeros.
// An item is accepted, then looked up in the table once per prime factor
// counted with multiplicity (at most fifteen) through the single table read
// port, reading one entry per cycle, and its result is then loaded into the
// output register. The next item is accepted only after that load.
// The output register holds a result until it is taken. While it is full the
// next item is still accepted and worked on, and its result waits for the
// register to be emptied. Reset restarts the sieve and discards any result.
module distinct_prime_factor_counter import dpfc_pkg::*; #(
    parameter int unsigned TABLE_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [15:0] value
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata   // [2:0] distinct_primes, [18:3] least_factor
);

    t_mem_ctl                sv_ctl;
    logic [TABLE_BITS-1:0]   sv_rd_addr;
    logic [TABLE_BITS-1:0]   sv_wr_addr;
    logic [2*TABLE_BITS-1:0] sv_wr_data;
    logic                    sv_done;
    logic                    q_rd_en;
    logic [TABLE_BITS-1:0]   q_rd_addr;
    logic                    ram_rd_en;
    logic [TABLE_BITS-1:0]   ram_rd_addr;
    logic [2*TABLE_BITS-1:0] ram_rd_data;

    assign ram_rd_en   = sv_done ? q_rd_en : sv_ctl.rd_en;
    assign ram_rd_addr = sv_done ? q_rd_addr : sv_rd_addr;

    dpfc_ram #(
        .WIDTH (2 * TABLE_BITS),
        .DEPTH (1 << TABLE_BITS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (sv_ctl.wr_en),
        .i_wr_addr (sv_wr_addr),
        .i_wr_data (sv_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    dpfc_sieve #(
        .TABLE_BITS (TABLE_BITS)
    ) u_sieve (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_data (ram_rd_data),
        .o_ctl     (sv_ctl),
        .o_rd_addr (sv_rd_addr),
        .o_wr_addr (sv_wr_addr),
        .o_wr_data (sv_wr_data),
        .o_done    (sv_done)
    );

    dpfc_query #(
        .TABLE_BITS (TABLE_BITS)
    ) u_query (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_enable      (sv_done),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_rd_data     (ram_rd_data),
        .o_rd_en       (q_rd_en),
        .o_rd_addr     (q_rd_addr)
    );

endmodule

>>> hw/rtl/dpfc_ram.sv
module dpfc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/dpfc_sieve.sv
`include "distinct_prime_factor_counter_defines.svh"

module dpfc_sieve import dpfc_pkg::*; #(
    parameter int unsigned TABLE_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [2*TABLE_BITS-1:0]   i_rd_data,
    output t_mem_ctl                  o_ctl,
    output logic [TABLE_BITS-1:0]     o_rd_addr,
    output logic [TABLE_BITS-1:0]     o_wr_addr,
    output logic [2*TABLE_BITS-1:0]   o_wr_data,
    output logic                      o_done
);

    localparam int unsigned IB         = TABLE_BITS;
    localparam int unsigned SQ_W       = 2 * TABLE_BITS;
    localparam int unsigned TABLE_SIZE = 1 << TABLE_BITS;

    t_sieve_state   r_state, n_state;
    logic [IB-1:0]  r_cnt, n_cnt;
    logic [IB-1:0]  r_i, n_i;
    logic [IB:0]    r_j, n_j;
    logic [IB-1:0]  r_k, n_k;
    logic           r_chk_vld, n_chk_vld;
    logic [IB-1:0]  r_chk_addr, n_chk_addr;
    logic [IB-1:0]  r_chk_k, n_chk_k;

    logic [IB-1:0]  rd_spf;
    logic [SQ_W-1:0] sq;
    logic           mark_we;

    assign rd_spf  = i_rd_data[IB-1:0];
    assign sq      = r_i * r_i;
    assign mark_we = r_chk_vld && (rd_spf == r_chk_addr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= SV_INIT;
            r_cnt     <= '0;
            r_chk_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_chk_vld <= n_chk_vld;
        end
        r_i        <= n_i;
        r_j        <= n_j;
        r_k        <= n_k;
        r_chk_addr <= n_chk_addr;
        r_chk_k    <= n_chk_k;
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_chk_vld  = 1'b0;
        n_chk_addr = r_chk_addr;
        n_chk_k    = r_chk_k;
        o_ctl      = '0;
        o_rd_addr  = r_i;
        o_wr_addr  = r_chk_addr;
        o_wr_data  = {r_chk_k, r_i};

        unique case (r_state)
            SV_INIT: begin
                o_ctl.wr_en = 1'b1;
                o_wr_addr   = r_cnt;
                o_wr_data   = (r_cnt < IB'(2)) ? '0 : {IB'(1), r_cnt};
                n_cnt       = r_cnt + IB'(1);
                if (&r_cnt) begin
                    n_i     = IB'(2);
                    n_state = SV_PRIME_RD;
                end
            end
            SV_PRIME_RD: begin
                if (sq >= SQ_W'(TABLE_SIZE)) begin
                    n_state = SV_DONE;
                end else begin
                    o_ctl.rd_en = 1'b1;
                    n_state     = SV_PRIME_CHK;
                end
            end
            SV_PRIME_CHK: begin
                if (rd_spf == r_i) begin
                    n_j     = (IB+1)'(sq);
                    n_k     = r_i;
                    n_state = SV_MARK;
                end else begin
                    n_i     = r_i + IB'(1);
                    n_state = SV_PRIME_RD;
                end
            end
            SV_MARK: begin
                if (!r_j[IB]) begin
                    o_ctl.rd_en = 1'b1;
                    o_rd_addr   = r_j[IB-1:0];
                    n_chk_vld   = 1'b1;
                    n_chk_addr  = r_j[IB-1:0];
                    n_chk_k     = r_k;
                    n_j         = r_j + (IB+1)'(r_i);
                    n_k         = r_k + IB'(1);
                end else begin
                    n_i     = r_i + IB'(1);
                    n_state = SV_PRIME_RD;
                end
            end
            SV_DONE: begin
            end
        endcase

        if (mark_we) begin
            o_ctl.wr_en = 1'b1;
        end
    end

    assign o_done = (r_state == SV_DONE);

    `DPFC_ASSERT(a_chk_only_in_mark, r_chk_vld |-> (r_state == SV_MARK))
    `DPFC_ASSERT(a_mark_below_index, mark_we |-> (r_i < r_chk_addr))
    `DPFC_ASSERT(a_done_sticks, o_done |=> o_done)

endmodule

>>> hw/rtl/dpfc_query.sv
`include "distinct_prime_factor_counter_defines.svh"

module dpfc_query import dpfc_pkg::*; #(
    parameter int unsigned TABLE_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_enable,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [S_TDATA_W-1:0]    s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [M_TDATA_W-1:0]    m_axis_tdata,
    input  logic [2*TABLE_BITS-1:0] i_rd_data,
    output logic                    o_rd_en,
    output logic [TABLE_BITS-1:0]   o_rd_addr
);

    localparam int unsigned IB = TABLE_BITS;

    t_query_state       r_state, n_state;
    logic [IB-1:0]      r_last, n_last;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [VALUE_W-1:0] r_first, n_first;
    logic               r_out_vld, n_out_vld;
    logic [COUNT_W-1:0] r_out_count, n_out_count;
    logic [VALUE_W-1:0] r_out_first, n_out_first;

    logic [IB-1:0]      rd_spf;
    logic [IB-1:0]      rd_cof;
    logic               accept;
    logic               in_range;
    logic               below_two;

    assign rd_spf    = i_rd_data[IB-1:0];
    assign rd_cof    = i_rd_data[2*IB-1:IB];
    assign s_axis_tready = (r_state == Q_IDLE) && i_enable;
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign in_range  = ((32'(s_axis_tdata[VALUE_W-1:0]) >> TABLE_BITS) == 32'd0);
    assign below_two = (s_axis_tdata[VALUE_W-1:0] < VALUE_W'(2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= Q_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
        r_last      <= n_last;
        r_count     <= n_count;
        r_first     <= n_first;
        r_out_count <= n_out_count;
        r_out_first <= n_out_first;
    end

    always_comb begin
        n_state     = r_state;
        n_last      = r_last;
        n_count     = r_count;
        n_first     = r_first;
        n_out_vld   = r_out_vld && !m_axis_tready;
        n_out_count = r_out_count;
        n_out_first = r_out_first;
        o_rd_en     = 1'b0;
        o_rd_addr   = IB'(s_axis_tdata[VALUE_W-1:0]);

        unique case (r_state)
            Q_IDLE: begin
                if (accept) begin
                    n_count = '0;
                    n_first = '0;
                    n_last  = '0;
                    if (in_range && !below_two) begin
                        o_rd_en = 1'b1;
                        n_state = Q_LOOK;
                    end else begin
                        n_state = Q_DONE;
                    end
                end
            end
            Q_LOOK: begin
                n_last = rd_spf;
                if (rd_spf != r_last) begin
                    n_count = r_count + COUNT_W'(1);
                    if (r_count == '0) begin
                        n_first = VALUE_W'(rd_spf);
                    end
                end
                if (rd_cof < IB'(2)) begin
                    n_state = Q_DONE;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = rd_cof;
                end
            end
            Q_DONE: begin
                if (!r_out_vld || m_axis_tready) begin
                    n_out_vld   = 1'b1;
                    n_out_count = r_count;
                    n_out_first = r_first;
                    n_state     = Q_IDLE;
                end
            end
        endcase
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {(M_TDATA_W-VALUE_W-COUNT_W)'(0), r_out_first, r_out_count};

    `DPFC_ASSERT(a_lookup_is_prime, (r_state == Q_LOOK) |-> (rd_spf >= IB'(2)))
    `DPFC_ASSERT(a_count_bounded, (r_state == Q_LOOK) |-> (r_count <= COUNT_W'(6)))
    `DPFC_ASSERT(a_ready_after_sieve, s_axis_tready |-> i_enable)

endmodule
